@@ src/bbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types and codes of the block buffer cache controller
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int TAG_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int HOLD_W   = 8;
    localparam int SECTOR_W = 35;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

    typedef enum logic [1:0] {
        REQ_ACQUIRE    = 2'd0,
        REQ_WRITE_BACK = 2'd1,
        REQ_RELEASE    = 2'd2,
        REQ_MARK_DIRTY = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HIT       = 3'd1,
        ST_MISS      = 3'd2,
        ST_NO_FREE   = 3'd3,
        ST_NOT_HELD  = 3'd4,
        ST_SATURATED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } disk_op_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan_step;
        logic decide;
        logic emit_single;
        logic emit_group;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_acquire;
        logic scan_last;
        logic use_group;
        logic can_load;
        logic group_done;
    } stat_t;

endpackage

@@ src/block_buffer_cache_lru_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit
// lru block buffer cache controller: tag lookup, eviction and sector commands
// ----------------------------------------------------------------------------
// acquire: accept, scan every entry in turn, decide, then emit each word as the result port takes it
// other requests: accept, decide, then emit each word as the result port takes it; no scan
// words per request: 1, or SECTORS_PER_BLOCK, or 2*SECTORS_PER_BLOCK on a dirty miss
// one request at a time: next accepted in the idle cycle after the last word loads
// result stalls hold the emit state; the serial entry scan sets the acquire time
// reset clears all entry state at once, ranks to NUM_ENTRIES-1-i, no sweep
module block_buffer_cache_lru_unit
#(
    parameter int NUM_ENTRIES       = 16,
    parameter int SECTORS_PER_BLOCK = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [bbc_pkg::TAG_W-1:0]     block_number,
    input  logic [bbc_pkg::SLOT_W-1:0]    slot,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    entry_index,
    output logic [2:0]                    status,
    output logic [1:0]                    disk_op,
    output logic [bbc_pkg::SECTOR_W-1:0]  disk_sector,
    output logic                          last
);
    import bbc_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: idle, scan entries, decide, emit word(s)
    bbc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry state, lru search and the registered result word
    bbc_datapath
    #(
        .NUM_ENTRIES       (NUM_ENTRIES),
        .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .block_number (block_number),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .entry_index  (entry_index),
        .status       (status),
        .disk_op      (disk_op),
        .disk_sector  (disk_sector),
        .last         (last)
    );

endmodule

@@ src/bbc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ctrl
// request sequencer: scan (acquire only), decide, then emit one word or a sector group
// ----------------------------------------------------------------------------
module bbc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bbc_pkg::stat_t stat,
    output bbc_pkg::cmd_t  cmd
);
    import bbc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SINGLE = 5'b01000,
        S_GROUP  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = stat.is_acquire ? S_SCAN : S_DECIDE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.use_group ? S_GROUP : S_SINGLE;
            end
            S_SINGLE:
            begin
                cmd.emit_single = 1'b1;
                if (stat.can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_GROUP:
            begin
                cmd.emit_group = 1'b1;
                if (stat.can_load && stat.group_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/bbc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_datapath
// entry state, serial tag/lru scan, decision logic and output word register
// ----------------------------------------------------------------------------
module bbc_datapath
#(
    parameter int NUM_ENTRIES       = 16,
    parameter int SECTORS_PER_BLOCK = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbc_pkg::cmd_t                 cmd,
    output bbc_pkg::stat_t                stat,
    input  logic [1:0]                    req_type,
    input  logic [bbc_pkg::TAG_W-1:0]     block_number,
    input  logic [bbc_pkg::SLOT_W-1:0]    slot,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    entry_index,
    output logic [2:0]                    status,
    output logic [1:0]                    disk_op,
    output logic [bbc_pkg::SECTOR_W-1:0]  disk_sector,
    output logic                          last
);
    import bbc_pkg::*;

    localparam int IDXW = $clog2(NUM_ENTRIES);
    localparam int CNTW = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(NUM_ENTRIES - 1);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(SECTORS_PER_BLOCK - 1);

    // entry state
    logic [TAG_W-1:0]  tag_reg   [NUM_ENTRIES];
    logic              valid_reg [NUM_ENTRIES];
    logic              dirty_reg [NUM_ENTRIES];
    logic [HOLD_W-1:0] hold_reg  [NUM_ENTRIES];
    logic [IDXW-1:0]   rank_reg  [NUM_ENTRIES];

    // latched request
    req_t              req_reg;
    logic [TAG_W-1:0]  blk_reg;
    logic [SLOT_W-1:0] slot_reg;

    // scan
    logic [IDXW-1:0]   scan_idx_reg;
    logic              hit_found_reg;
    logic [IDXW-1:0]   hit_idx_reg;
    logic [IDXW-1:0]   hit_rank_reg;
    logic              lru_found_reg;
    logic [IDXW-1:0]   lru_idx_reg;
    logic [IDXW-1:0]   lru_rank_reg;

    // pending words
    logic [3:0]          sgl_idx_reg;
    status_t             sgl_status_reg;
    logic [3:0]          grp_idx_reg;
    status_t             grp_status_reg;
    disk_op_t            grp_op_reg;
    logic [SECTOR_W-1:0] grp_base_reg;
    logic [SECTOR_W-1:0] rd_base_reg;
    logic [CNTW-1:0]     grp_cnt_reg;
    logic                grp_second_reg;

    // output word
    logic                out_valid_reg;
    logic [3:0]          out_idx_reg;
    status_t             out_status_reg;
    disk_op_t            out_op_reg;
    logic [SECTOR_W-1:0] out_sector_reg;
    logic                out_last_reg;

    logic can_load;
    logic cnt_last;
    logic load_word;
    logic scan_hit;
    logic scan_lru;

    // decision
    logic            slot_out;
    logic [IDXW-1:0] slot_idx;
    logic            dec_group;
    logic [IDXW-1:0] dec_idx;
    status_t         dec_status;
    logic [3:0]      dec_out_idx;
    disk_op_t        dec_op;
    logic [TAG_W-1:0] dec_tag;
    logic            dec_second;
    logic            do_inc;
    logic            do_dec;
    logic            do_promote;
    logic            do_fill;
    logic            do_set_dirty;
    logic            do_clr_dirty;
    logic [NUM_ENTRIES-1:0] rank_zero;

    assign can_load = !out_valid_reg || !out_stall;
    assign cnt_last = (grp_cnt_reg == CNT_LAST);
    assign load_word = can_load && (cmd.emit_single || cmd.emit_group);

    assign stat.is_acquire = (req_type == REQ_ACQUIRE);
    assign stat.scan_last  = (scan_idx_reg == IDX_LAST);
    assign stat.use_group  = dec_group;
    assign stat.can_load   = can_load;
    assign stat.group_done = cnt_last && !grp_second_reg;

    assign scan_hit = valid_reg[scan_idx_reg] && (tag_reg[scan_idx_reg] == blk_reg)
                      && (!hit_found_reg || (rank_reg[scan_idx_reg] < hit_rank_reg));
    assign scan_lru = (hold_reg[scan_idx_reg] == '0)
                      && (!lru_found_reg || (rank_reg[scan_idx_reg] > lru_rank_reg));

    assign slot_out = (32'(slot_reg) >= NUM_ENTRIES);
    assign slot_idx = IDXW'(slot_reg);

    always_comb
    begin
        dec_group    = 1'b0;
        dec_idx      = slot_idx;
        dec_status   = ST_OK;
        dec_out_idx  = slot_reg;
        dec_op       = OP_WRITE;
        dec_tag      = tag_reg[slot_idx];
        dec_second   = 1'b0;
        do_inc       = 1'b0;
        do_dec       = 1'b0;
        do_promote   = 1'b0;
        do_fill      = 1'b0;
        do_set_dirty = 1'b0;
        do_clr_dirty = 1'b0;
        if (req_reg == REQ_ACQUIRE)
        begin
            if (hit_found_reg)
            begin
                dec_idx     = hit_idx_reg;
                dec_out_idx = 4'(hit_idx_reg);
                if (hold_reg[hit_idx_reg] == HOLD_MAX)
                begin
                    dec_status = ST_SATURATED;
                end
                else
                begin
                    dec_status = ST_HIT;
                    do_inc     = 1'b1;
                    do_promote = 1'b1;
                end
            end
            else if (!lru_found_reg)
            begin
                dec_status  = ST_NO_FREE;
                dec_out_idx = 4'd0;
            end
            else
            begin
                dec_idx     = lru_idx_reg;
                dec_out_idx = 4'(lru_idx_reg);
                dec_status  = ST_MISS;
                dec_group   = 1'b1;
                do_fill     = 1'b1;
                do_promote  = 1'b1;
                if (dirty_reg[lru_idx_reg])
                begin
                    dec_op     = OP_WRITE;
                    dec_tag    = tag_reg[lru_idx_reg];
                    dec_second = 1'b1;
                end
                else
                begin
                    dec_op  = OP_READ;
                    dec_tag = blk_reg;
                end
            end
        end
        else if (slot_out)
        begin
            dec_status = ST_NOT_HELD;
        end
        else if (req_reg == REQ_MARK_DIRTY)
        begin
            do_set_dirty = 1'b1;
        end
        else if (hold_reg[slot_idx] == '0)
        begin
            dec_status = ST_NOT_HELD;
        end
        else if (req_reg == REQ_WRITE_BACK)
        begin
            dec_group    = 1'b1;
            do_clr_dirty = 1'b1;
        end
        else
        begin
            do_dec = 1'b1;
        end
    end

    // request latch and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= REQ_ACQUIRE;
            blk_reg       <= '0;
            slot_reg      <= '0;
            scan_idx_reg  <= '0;
            hit_found_reg <= 1'b0;
            hit_idx_reg   <= '0;
            hit_rank_reg  <= '0;
            lru_found_reg <= 1'b0;
            lru_idx_reg   <= '0;
            lru_rank_reg  <= '0;
        end
        else if (cmd.start)
        begin
            req_reg       <= req_t'(req_type);
            blk_reg       <= block_number;
            slot_reg      <= slot;
            scan_idx_reg  <= '0;
            hit_found_reg <= 1'b0;
            lru_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (scan_hit)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= scan_idx_reg;
                hit_rank_reg  <= rank_reg[scan_idx_reg];
            end
            if (scan_lru)
            begin
                lru_found_reg <= 1'b1;
                lru_idx_reg   <= scan_idx_reg;
                lru_rank_reg  <= rank_reg[scan_idx_reg];
            end
        end
    end

    // entry state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                tag_reg[i]   <= '0;
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                hold_reg[i]  <= '0;
                rank_reg[i]  <= IDXW'(NUM_ENTRIES - 1 - i);
            end
        end
        else if (cmd.decide)
        begin
            if (do_promote)
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (rank_reg[i] < rank_reg[dec_idx])
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                rank_reg[dec_idx] <= '0;
            end
            if (do_inc)
            begin
                hold_reg[dec_idx] <= hold_reg[dec_idx] + 1'b1;
            end
            if (do_dec)
            begin
                hold_reg[dec_idx] <= hold_reg[dec_idx] - 1'b1;
            end
            if (do_fill)
            begin
                tag_reg[dec_idx]   <= blk_reg;
                valid_reg[dec_idx] <= 1'b1;
                dirty_reg[dec_idx] <= 1'b0;
                hold_reg[dec_idx]  <= HOLD_W'(1);
            end
            if (do_set_dirty)
            begin
                dirty_reg[dec_idx] <= 1'b1;
            end
            if (do_clr_dirty)
            begin
                dirty_reg[dec_idx] <= 1'b0;
            end
        end
    end

    // pending word setup and sector group sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_cnt_reg    <= '0;
            grp_second_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            grp_cnt_reg    <= '0;
            grp_second_reg <= dec_second;
        end
        else if (cmd.emit_group && can_load && cnt_last)
        begin
            grp_cnt_reg    <= '0;
            grp_second_reg <= 1'b0;
        end
        else if (cmd.emit_group && can_load)
        begin
            grp_cnt_reg <= grp_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            sgl_idx_reg    <= dec_out_idx;
            sgl_status_reg <= dec_status;
            grp_idx_reg    <= dec_out_idx;
            grp_status_reg <= dec_status;
            grp_op_reg     <= dec_op;
            grp_base_reg   <= SECTOR_W'(dec_tag) * SECTOR_W'(SECTORS_PER_BLOCK);
            rd_base_reg    <= SECTOR_W'(blk_reg) * SECTOR_W'(SECTORS_PER_BLOCK);
        end
        else if (cmd.emit_group && can_load && cnt_last && grp_second_reg)
        begin
            grp_op_reg   <= OP_READ;
            grp_base_reg <= rd_base_reg;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            out_valid_reg <= load_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && cmd.emit_single)
        begin
            out_idx_reg    <= sgl_idx_reg;
            out_status_reg <= sgl_status_reg;
            out_op_reg     <= OP_NONE;
            out_sector_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (can_load && cmd.emit_group)
        begin
            out_idx_reg    <= grp_idx_reg;
            out_status_reg <= grp_status_reg;
            out_op_reg     <= grp_op_reg;
            out_sector_reg <= grp_base_reg + SECTOR_W'(grp_cnt_reg);
            out_last_reg   <= cnt_last && !grp_second_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_idx_reg;
    assign status      = out_status_reg;
    assign disk_op     = out_op_reg;
    assign disk_sector = out_sector_reg;
    assign last        = out_last_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            rank_zero[i] = (rank_reg[i] == '0);
        end
    end

    // recency ranks stay a permutation: exactly one most recent entry
    a_one_mru: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(rank_zero))
        else $error("recency ranks lost their single most recent entry");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        grp_cnt_reg <= CNT_LAST)
        else $error("sector counter past block size");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_single && can_load) |=> (out_valid_reg && out_last_reg))
        else $error("single word not flagged last");

endmodule

@@ tb/block_buffer_cache_lru_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit_tb
// drives random and directed cache requests through the valid/stall request
// port, predicts every sector command and status word in a scoreboard class,
// and compares each word leaving the result port against the oldest prediction
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit_tb;
    import bbc_pkg::*;

    localparam int NENT = 16;
    localparam int SPB  = 2;

    typedef struct packed {
        logic [3:0]          entry;
        status_t             st;
        disk_op_t            op;
        logic [SECTOR_W-1:0] sector;
        logic                fin;
    } cache_word_t;

    // predicted cache state plus the queue of words still to come out
    class cache_scoreboard;
        logic [TAG_W-1:0]  tags  [NENT];
        logic              valid [NENT];
        logic              dirty [NENT];
        logic [HOLD_W-1:0] holds [NENT];
        int unsigned       rank  [NENT];
        cache_word_t       pending[$];
        int                errors;

        function void clear_state();
            for (int i = 0; i < NENT; i++)
            begin
                tags[i] = '0;
                valid[i] = 1'b0;
                dirty[i] = 1'b0;
                holds[i] = '0;
                rank[i] = NENT - 1 - i;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void push(int e, status_t st, disk_op_t op, logic [SECTOR_W-1:0] sec,
                           logic fin);
            cache_word_t w;
            w.entry = e[3:0];
            w.st = st;
            w.op = op;
            w.sector = sec;
            w.fin = fin;
            pending.push_back(w);
        endfunction

        function void make_recent(int e);
            int unsigned r;
            r = rank[e];
            for (int i = 0; i < NENT; i++)
                if (rank[i] < r)
                    rank[i]++;
            rank[e] = 0;
        endfunction

        function void push_sectors(int e, status_t st, disk_op_t op, logic [TAG_W-1:0] tag,
                                   logic fin_group);
            logic [SECTOR_W-1:0] base;
            base = SECTOR_W'(tag) * SECTOR_W'(SPB);
            for (int i = 0; i < SPB; i++)
                push(e, st, op, base + SECTOR_W'(i), fin_group && (i == SPB - 1));
        endfunction

        // note an accepted request and predict its words
        function void note_request(req_t req, logic [TAG_W-1:0] blk, logic [3:0] s);
            int  e;
            bit  found;
            e = 0;
            found = 0;
            if (req == REQ_ACQUIRE)
            begin
                for (int i = 0; i < NENT; i++)
                    if (valid[i] && tags[i] == blk && (!found || rank[i] < rank[e]))
                    begin
                        e = i;
                        found = 1;
                    end
                if (found)
                begin
                    if (holds[e] == HOLD_MAX)
                        push(e, ST_SATURATED, OP_NONE, '0, 1'b1);
                    else
                    begin
                        holds[e]++;
                        make_recent(e);
                        push(e, ST_HIT, OP_NONE, '0, 1'b1);
                    end
                    return;
                end
                for (int i = 0; i < NENT; i++)
                    if (holds[i] == 0 && (!found || rank[i] > rank[e]))
                    begin
                        e = i;
                        found = 1;
                    end
                if (!found)
                begin
                    push(0, ST_NO_FREE, OP_NONE, '0, 1'b1);
                    return;
                end
                // dirty victim goes out at its old address first
                if (dirty[e])
                    push_sectors(e, ST_MISS, OP_WRITE, tags[e], 1'b0);
                tags[e] = blk;
                dirty[e] = 1'b0;
                holds[e] = HOLD_W'(1);
                valid[e] = 1'b1;
                push_sectors(e, ST_MISS, OP_READ, blk, 1'b1);
                make_recent(e);
                return;
            end
            if (req == REQ_MARK_DIRTY)
            begin
                dirty[s] = 1'b1;
                push(s, ST_OK, OP_NONE, '0, 1'b1);
            end
            else if (holds[s] == 0)
                push(s, ST_NOT_HELD, OP_NONE, '0, 1'b1);
            else if (req == REQ_WRITE_BACK)
            begin
                push_sectors(s, ST_OK, OP_WRITE, tags[s], 1'b1);
                dirty[s] = 1'b0;
            end
            else
            begin
                holds[s]--;
                push(s, ST_OK, OP_NONE, '0, 1'b1);
            end
        endfunction

        function void check_word(cache_word_t got);
            cache_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.entry != exp_w.entry)
            begin
                $display("%0t: entry_index expected %0d actual %0d", $time, exp_w.entry,
                         got.entry);
                errors++;
            end
            if (got.st != exp_w.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp_w.st, got.st);
                errors++;
            end
            if (got.op != exp_w.op)
            begin
                $display("%0t: disk_op expected %0d actual %0d", $time, exp_w.op, got.op);
                errors++;
            end
            if (got.sector != exp_w.sector)
            begin
                $display("%0t: disk_sector expected %0h actual %0h", $time, exp_w.sector,
                         got.sector);
                errors++;
            end
            if (got.fin != exp_w.fin)
            begin
                $display("%0t: last expected %0b actual %0b", $time, exp_w.fin, got.fin);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           req_type;
    logic [TAG_W-1:0]     block_number;
    logic [SLOT_W-1:0]    slot;
    logic                 out_valid;
    logic                 out_stall;
    logic [3:0]           entry_index;
    logic [2:0]           status;
    logic [1:0]           disk_op;
    logic [SECTOR_W-1:0]  disk_sector;
    logic                 last;

    cache_scoreboard sb;
    bit  hold_off_req;   // asks the result side for a long stall
    bit  burst_mode;     // sender pauses off during directed part
    int  burst_left;
    logic [TAG_W-1:0] hot_blocks[8];

    block_buffer_cache_lru_unit #(.NUM_ENTRIES(NENT), .SECTORS_PER_BLOCK(SPB)) dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .block_number(block_number), .slot(slot),
        .out_valid(out_valid), .out_stall(out_stall),
        .entry_index(entry_index), .status(status), .disk_op(disk_op),
        .disk_sector(disk_sector), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // send one request word and wait for it to be taken; in burst mode, bursts with random gaps
    // valid stays high after a take so back to back words need no gap
    task automatic send_request(req_t req, logic [TAG_W-1:0] blk, logic [3:0] s);
        if (burst_mode)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        req_type <= req;
        block_number <= blk;
        slot <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(req, blk, s);
    endtask

    // sender pause until the cache has answered everything
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (sb.pending.size() != 0 && guard < 100000);
    endtask

    // result side: checks at each accepting edge, stalls on its own pattern
    initial
    begin
        int phase;
        int pause;
        out_stall = 1'b0;
        phase = 0;
        pause = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_word('{entry_index, status_t'(status), disk_op_t'(disk_op),
                                disk_sector, last});
            phase++;
            if (hold_off_req)
            begin
                hold_off_req = 0;
                pause = 400;
            end
            if (pause > 0)
            begin
                pause--;
                out_stall <= 1'b1;
            end
            else if ((phase / 64) % 3 == 2)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic random_request();
        int   pick;
        logic [TAG_W-1:0] blk;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            blk = $urandom();
        else
            blk = hot_blocks[$urandom_range(0, 7)];
        // acquire-heavy mix; releases keep holds from piling up
        if (pick < 45)
            send_request(REQ_ACQUIRE, blk, 4'($urandom()));
        else if (pick < 70)
            send_request(REQ_RELEASE, $urandom(), 4'($urandom()));
        else if (pick < 85)
            send_request(REQ_MARK_DIRTY, $urandom(), 4'($urandom()));
        else
            send_request(REQ_WRITE_BACK, $urandom(), 4'($urandom()));
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        hold_off_req = 0;
        burst_mode = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_ACQUIRE;
        block_number = '0;
        slot = '0;
        for (int i = 0; i < 8; i++)
            hot_blocks[i] = (i == 7) ? 32'hFFFF_FFFF : $urandom_range(0, 40);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero tag against invalid entries, extremes, not held cases
        send_request(REQ_RELEASE, '0, 4'd0);
        send_request(REQ_WRITE_BACK, '0, 4'd15);
        send_request(REQ_ACQUIRE, 32'd0, '0);
        send_request(REQ_ACQUIRE, 32'hFFFF_FFFF, '1);
        send_request(REQ_ACQUIRE, 32'hFFFF_FFFF, '0);
        send_request(REQ_MARK_DIRTY, '0, 4'd14);
        send_request(REQ_WRITE_BACK, '1, 4'd14);
        send_request(REQ_MARK_DIRTY, '0, 4'd15);
        send_request(REQ_RELEASE, '0, 4'd14);
        send_request(REQ_RELEASE, '0, 4'd14);
        send_request(REQ_RELEASE, '0, 4'd14);
        // dirty eviction of the unheld entries marked dirty: write at their old tag
        for (int i = 1; i <= 15; i++)
            send_request(REQ_ACQUIRE, 32'h8000_0000 + i, '0);
        drain();

        // every entry is already held, so these acquires find no free entry
        for (int i = 0; i < 17; i++)
            send_request(REQ_ACQUIRE, 32'h1000 + i, '0);
        drain();

        // release everything so random acquires can miss
        for (int s = 0; s < NENT; s++)
            while (sb.holds[s] != 0)
                send_request(REQ_RELEASE, '0, 4'(s));
        drain();

        // long result stall while requests keep arriving
        burst_mode = 1;
        hold_off_req = 1;
        for (int i = 0; i < 40; i++)
            random_request();
        drain();
        for (int i = 0; i < 180; i++)
            random_request();
        drain();
        repeat (100) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
